@@ src/ehd_pkg.sv @@
// shared types, constants and the holiday offset table for the holy day date unit
package ehd_pkg;

    localparam int YEAR_W    = 14;
    localparam int HOLIDAY_W = 3;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int DOY_W     = 7;
    localparam int DOYX_W    = 8;

    localparam logic [HOLIDAY_W-1:0] HOLY_FIRST = 3'd0;
    localparam logic [HOLIDAY_W-1:0] HOLY_LAST  = 3'd5;

    // easter as day of year plus the leap flag
    typedef struct packed {
        logic [DOY_W-1:0] edoy;
        logic             leap;
    } ehd_res_t;

    // day offset from easter, two's complement in DOYX_W bits
    function automatic logic [DOYX_W-1:0] holy_offset(input logic [HOLIDAY_W-1:0] idx);
        logic [DOYX_W-1:0] ofs;
        case (idx)
            3'd0:    ofs = 8'd207;
            3'd1:    ofs = 8'd209;
            3'd2:    ofs = 8'd254;
            3'd3:    ofs = 8'd0;
            3'd4:    ofs = 8'd39;
            3'd5:    ofs = 8'd49;
            default: ofs = 8'd0;
        endcase
        return ofs;
    endfunction

endpackage

@@ src/easter_holy_day_dates_unit.sv @@
// holy day date unit: gregorian year in, six dated holiday results out
//
// a request on the s_ side carries a year in s_tdata[13:0]; it is taken when
// s_tvalid and s_tready are both high. for each year six results leave on the
// m_ side, one per accepted transfer: carnival start, carnival end, good
// friday, easter, ascension, whitsun. m_tuser holds the holiday index,
// m_tdata holds month and day, m_tlast marks the sixth result.
// the first result reaches m_tvalid through the nine computus stages, the
// hold register and the output register.
// the single result port sends the six results of a year one by one; the
// next year waits in the pipeline while the current one is sent out.
// reset clears all valid bits, so the pipeline and output come up empty.
// when the receiver holds m_tready low, the output and hold registers keep
// their contents, valid stages close up over empty ones, and s_tready drops
// once the pipeline is full; nothing is lost or repeated.
module easter_holy_day_dates_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // year[13:0], zero[15:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // month[3:0], day_of_month[8:4], zero[15:9]
    output logic [2:0]  m_tuser,   // holiday[2:0]
    output logic        m_tlast
);

    logic                         cmp_valid;
    logic                         cmp_ready;
    ehd_pkg::ehd_res_t            cmp_res;
    logic [ehd_pkg::MONTH_W-1:0]  res_month;
    logic [ehd_pkg::DAY_W-1:0]    day_of_month;

    ehd_computus u_computus
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_year   (s_tdata[ehd_pkg::YEAR_W-1:0]),
        .out_valid (cmp_valid),
        .out_ready (cmp_ready),
        .out_res   (cmp_res)
    );

    ehd_expand u_expand
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cmp_valid),
        .in_ready     (cmp_ready),
        .in_res       (cmp_res),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .holiday      (m_tuser),
        .month        (res_month),
        .day_of_month (day_of_month),
        .last         (m_tlast)
    );

    assign m_tdata = {7'd0, day_of_month, res_month};

endmodule

@@ src/ehd_computus.sv @@
// nine stage pipeline computing easter as a day of the year
module ehd_computus
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ehd_pkg::YEAR_W-1:0]  in_year,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ehd_pkg::ehd_res_t           out_res
);

    localparam int NUM_STAGES = 9;

    typedef struct packed {
        logic [13:0] year;
        logic [7:0]  b;
        logic [9:0]  q19;
        logic [4:0]  a;
        logic [6:0]  c;
        logic [2:0]  f;
        logic [5:0]  g;
        logic [9:0]  xh;
        logic        leap;
        logic [4:0]  qh;
        logic [4:0]  h;
        logic [6:0]  lx;
        logic [3:0]  ql;
        logic [2:0]  l;
        logic [8:0]  mx;
        logic [6:0]  edoy;
    } cmp_t;

    cmp_t                  st_reg  [NUM_STAGES];
    cmp_t                  st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES:0]   adv;

    logic [26:0] prod_b;
    logic [29:0] prod_19;
    logic [13:0] rem_100;
    logic [13:0] rem_19;
    logic [14:0] prod_f;
    logic [7:0]  gx;
    logic [15:0] prod_g;
    logic [20:0] prod_h;
    logic [9:0]  rem_h;
    logic [14:0] prod_l;
    logic [6:0]  rem_l;
    logic        m;

    assign adv[NUM_STAGES] = out_ready;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_STAGES; gi++) begin : g_stage
            assign adv[gi] = !vld_reg[gi] || adv[gi+1];
            if (gi == 0) begin : g_first
                assign vld_next[gi] = in_valid;
            end
            else begin : g_rest
                assign vld_next[gi] = vld_reg[gi-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[gi] <= 1'b0;
                end
                else if (adv[gi])
                begin
                    vld_reg[gi] <= vld_next[gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[gi])
                begin
                    st_reg[gi] <= st_next[gi];
                end
            end
        end
    endgenerate

    always_comb
    begin
        // stage 0: quotients by 100 and 19
        st_next[0]      = '0;
        st_next[0].year = in_year;
        prod_b          = 27'(in_year) * 27'd5243;
        prod_19         = 30'(in_year) * 30'd55189;
        st_next[0].b    = prod_b[26:19];
        st_next[0].q19  = prod_19[29:20];

        // stage 1: remainders and f
        st_next[1]   = st_reg[0];
        rem_100      = st_reg[0].year - 14'(st_reg[0].b) * 14'd100;
        rem_19       = st_reg[0].year - 14'(st_reg[0].q19) * 14'd19;
        st_next[1].c = rem_100[6:0];
        st_next[1].a = rem_19[4:0];
        prod_f       = 15'(9'(st_reg[0].b) + 9'd8) * 15'd41;
        st_next[1].f = prod_f[12:10];

        // stage 2: g
        st_next[2]   = st_reg[1];
        gx           = st_reg[1].b - 8'(st_reg[1].f) + 8'd1;
        prod_g       = 16'(gx) * 16'd171;
        st_next[2].g = prod_g[14:9];

        // stage 3: sum ahead of the mod 30, leap year flag
        st_next[3]    = st_reg[2];
        st_next[3].xh = 10'(st_reg[2].a) * 10'd19 + 10'(st_reg[2].b)
                        - 10'(st_reg[2].b[7:2]) - 10'(st_reg[2].g) + 10'd15;
        st_next[3].leap = (st_reg[2].c != 7'd0) ? (st_reg[2].year[1:0] == 2'd0)
                                                : (st_reg[2].b[1:0] == 2'd0);

        // stage 4: quotient by 30
        st_next[4]    = st_reg[3];
        prod_h        = 21'(st_reg[3].xh) * 21'd1093;
        st_next[4].qh = prod_h[19:15];

        // stage 5: h and sum ahead of the mod 7
        st_next[5]    = st_reg[4];
        rem_h         = st_reg[4].xh - 10'(st_reg[4].qh) * 10'd30;
        st_next[5].h  = rem_h[4:0];
        st_next[5].lx = 7'd32 + 7'({st_reg[4].b[1:0], 1'b0})
                        + 7'({st_reg[4].c[6:2], 1'b0})
                        - 7'(rem_h[4:0]) - 7'(st_reg[4].c[1:0]);

        // stage 6: quotient by 7
        st_next[6]    = st_reg[5];
        prod_l        = 15'(st_reg[5].lx) * 15'd147;
        st_next[6].ql = prod_l[13:10];

        // stage 7: l and the sum ahead of the 451 compare
        st_next[7]    = st_reg[6];
        rem_l         = st_reg[6].lx - 7'(st_reg[6].ql) * 7'd7;
        st_next[7].l  = rem_l[2:0];
        st_next[7].mx = 9'(st_reg[6].a) + 9'(st_reg[6].h) * 9'd11 + 9'(rem_l[2:0]) * 9'd22;

        // stage 8: easter day of year
        st_next[8]      = st_reg[7];
        m               = (st_reg[7].mx >= 9'd451);
        st_next[8].edoy = 7'(st_reg[7].h) + 7'(st_reg[7].l) + 7'd81 + 7'(st_reg[7].leap)
                          - (m ? 7'd7 : 7'd0);
    end

    assign in_ready     = adv[0];
    assign out_valid    = vld_reg[NUM_STAGES-1];
    assign out_res.edoy = st_reg[NUM_STAGES-1].edoy;
    assign out_res.leap = st_reg[NUM_STAGES-1].leap;

endmodule

@@ src/ehd_expand.sv @@
// sequencer turning one easter date into six dated holiday results
module ehd_expand
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ehd_pkg::ehd_res_t              in_res,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ehd_pkg::HOLIDAY_W-1:0]  holiday,
    output logic [ehd_pkg::MONTH_W-1:0]    month,
    output logic [ehd_pkg::DAY_W-1:0]      day_of_month,
    output logic                           last
);

    logic                           hold_vld_reg;
    logic [ehd_pkg::DOY_W-1:0]      edoy_reg;
    logic                           leap_reg;
    logic [ehd_pkg::HOLIDAY_W-1:0]  idx_reg;
    logic [ehd_pkg::HOLIDAY_W-1:0]  idx_next;
    logic                           out_vld_reg;
    logic [ehd_pkg::HOLIDAY_W-1:0]  holiday_reg;
    logic [ehd_pkg::MONTH_W-1:0]    month_reg;
    logic [ehd_pkg::DAY_W-1:0]      day_reg;
    logic                           last_reg;

    logic                           out_load;
    logic                           emit;
    logic                           end_item;
    logic [ehd_pkg::DOYX_W-1:0]     doy;
    logic [ehd_pkg::DOYX_W-1:0]     lp;
    logic [ehd_pkg::DOYX_W-1:0]     day_full;
    logic [ehd_pkg::MONTH_W-1:0]    month_next;
    logic [ehd_pkg::DAY_W-1:0]      day_next;

    assign out_load = !out_vld_reg || out_ready;
    assign emit     = hold_vld_reg && out_load;
    assign end_item = emit && (idx_reg == ehd_pkg::HOLY_LAST);
    assign in_ready = !hold_vld_reg || end_item;

    always_comb
    begin
        idx_next = idx_reg;
        if (end_item)
        begin
            idx_next = ehd_pkg::HOLY_FIRST;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    // day of year to month and day, january through june
    always_comb
    begin
        doy = 8'(edoy_reg) + ehd_pkg::holy_offset(idx_reg);
        lp  = 8'(leap_reg);
        if (doy <= 8'd31)
        begin
            month_next = 4'd1;
            day_full   = doy;
        end
        else if (doy <= 8'd59 + lp)
        begin
            month_next = 4'd2;
            day_full   = doy - 8'd31;
        end
        else if (doy <= 8'd90 + lp)
        begin
            month_next = 4'd3;
            day_full   = doy - 8'd59 - lp;
        end
        else if (doy <= 8'd120 + lp)
        begin
            month_next = 4'd4;
            day_full   = doy - 8'd90 - lp;
        end
        else if (doy <= 8'd151 + lp)
        begin
            month_next = 4'd5;
            day_full   = doy - 8'd120 - lp;
        end
        else
        begin
            month_next = 4'd6;
            day_full   = doy - 8'd151 - lp;
        end
        day_next = day_full[ehd_pkg::DAY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            idx_reg      <= ehd_pkg::HOLY_FIRST;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                hold_vld_reg <= in_valid;
            end
            idx_reg <= idx_next;
            if (out_load)
            begin
                out_vld_reg <= hold_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            edoy_reg <= in_res.edoy;
            leap_reg <= in_res.leap;
        end
        if (emit)
        begin
            holiday_reg <= idx_reg;
            month_reg   <= month_next;
            day_reg     <= day_next;
            last_reg    <= (idx_reg == ehd_pkg::HOLY_LAST);
        end
    end

    assign out_valid    = out_vld_reg;
    assign holiday      = holiday_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign last         = last_reg;

endmodule
